// ----- rtl/core/asa_pkg.sv -----
`timescale 1ns / 1ps

package asa_pkg;

    // Fixed field widths of the command and result transfers.
    localparam int KIND_W     = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int PORT_ID_W  = 16;
    localparam int COUNT_W    = 32;

    // Command codes.
    localparam logic [KIND_W-1:0] KIND_BOOK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CAS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SETP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [PORT_ID_W-1:0]  function_id;
        logic [SLOT_IDX_W-1:0] home_domain;
        logic [SLOT_IDX_W-1:0] target_domain;
        logic [PORT_ID_W-1:0]  expected_id;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] granted_domain;
        logic                  success;
        logic [PORT_ID_W-1:0]  owner_id;
        logic [PORT_ID_W-1:0]  previous_id;
        logic [PORT_ID_W-1:0]  primary_id;
        logic [COUNT_W-1:0]    usage_count;
    } t_result;

    // Status of one slot as seen by the shared evaluation unit.
    typedef struct packed {
        logic free;
        logic last_empty;
        logic ok;
        logic wr;
        logic claim;
    } t_eval;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK,
        ST_APPLY
    } t_state;

endpackage

// ----- rtl/core/asa_ram.sv -----
`timescale 1ns / 1ps

module asa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/asa_slot_eval.sv -----
`timescale 1ns / 1ps

module asa_slot_eval #(
    parameter int ID_BITS = 16
) (
    input  logic [asa_pkg::KIND_W-1:0] i_kind,
    input  logic [ID_BITS-1:0]         i_id,
    input  logic [ID_BITS-1:0]         i_expected,
    input  logic                       i_slot_zero,
    input  logic [ID_BITS-1:0]         i_owner,
    input  logic [ID_BITS-1:0]         i_last,
    input  logic [ID_BITS-1:0]         i_primary,
    output logic [ID_BITS-1:0]         o_owner,
    output logic [ID_BITS-1:0]         o_last,
    output logic [ID_BITS-1:0]         o_primary,
    output asa_pkg::t_eval             o_stat
);

    import asa_pkg::*;

    // Shared compare unit: used for every slot of a search and for the final update.
    always_comb begin
        o_owner           = i_owner;
        o_last            = i_last;
        o_primary         = i_primary;
        o_stat            = '0;
        o_stat.free       = (i_owner == '0);
        o_stat.last_empty = (i_last == '0);
        case (i_kind)
            KIND_BOOK: begin
                if (o_stat.free) begin
                    o_owner      = i_id;
                    o_last       = i_id;
                    o_stat.ok    = 1'b1;
                    o_stat.wr    = 1'b1;
                    o_stat.claim = 1'b1;
                end
            end
            KIND_CAS: begin
                if (!i_slot_zero && i_owner == i_expected) begin
                    o_owner   = i_id;
                    o_stat.ok = 1'b1;
                    o_stat.wr = 1'b1;
                end
            end
            KIND_CANCEL: begin
                if (i_last == i_id) begin
                    o_last    = '0;
                    o_primary = '0;
                    o_stat.wr = 1'b1;
                end
            end
            KIND_SETP: begin
                o_primary = i_id;
                o_stat.wr = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/affinity_slot_allocator.sv -----
// A request that fails early is answered from idle; a request on one slot reads it (ST_LOOK)
// and then updates it (ST_APPLY); a search booking scans the table first, then does the same.
// Throughput: one command at a time; busy stays high until the result strobe is issued.
// The search is bounded by one slot-table read per cycle through the shared compare unit.
// Synchronous active-low reset empties all slots at once and clears the usage count.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
`timescale 1ns / 1ps

module affinity_slot_allocator #(
    parameter int SLOT_COUNT        = 16,
    parameter int ID_BITS           = 16,
    parameter int FIRST_SEARCH_SLOT = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  asa_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_done,
    output asa_pkg::t_result o_result
);

    import asa_pkg::*;

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int SCAN_MAX = (SLOT_COUNT > FIRST_SEARCH_SLOT) ? SLOT_COUNT : FIRST_SEARCH_SLOT;
    localparam int SCAN_W   = $clog2(SCAN_MAX + 1);
    localparam int ROW_W    = 3 * ID_BITS;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [SLOT_W-1:0]   r_addr, n_addr;
    logic [SCAN_W-1:0]   r_scan, n_scan;
    logic [SLOT_W-1:0]   r_chk_idx, n_chk_idx;
    logic                r_chk_v, n_chk_v;
    logic                r_free_found, n_free_found;
    logic [SLOT_W-1:0]   r_free_idx, n_free_idx;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic                r_rd_valid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_done, n_done;
    t_result             r_result, n_result;

    logic [SLOT_W-1:0]   rd_addr;
    logic                rd_in_range;
    logic [ROW_W-1:0]    ram_q;
    logic [ROW_W-1:0]    row;
    logic                ram_we;
    logic [ID_BITS-1:0]  new_owner, new_last, new_primary;
    logic [ID_BITS-1:0]  cmd_id, cmd_expected, in_id;
    t_eval               stat;

    logic                issue, hit, cand, at_last, none_left;

    assign cmd_id       = ID_BITS'(r_cmd.function_id);
    assign cmd_expected = ID_BITS'(r_cmd.expected_id);
    assign in_id        = ID_BITS'(i_cmd.function_id);

    // Table read address: the search index while scanning, else the addressed slot.
    assign rd_addr     = (r_state == ST_SCAN) ? r_scan[SLOT_W-1:0] : r_addr;
    assign rd_in_range = (int'(rd_addr) < SLOT_COUNT);

    // Slots never written since reset read as empty.
    assign row = r_rd_valid ? ram_q : '0;

    asa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata ({new_owner, new_last, new_primary}),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    asa_slot_eval #(
        .ID_BITS (ID_BITS)
    ) u_eval (
        .i_kind      (r_cmd.kind),
        .i_id        (cmd_id),
        .i_expected  (cmd_expected),
        .i_slot_zero (r_addr == '0),
        .i_owner     (row[ROW_W-1 -: ID_BITS]),
        .i_last      (row[2*ID_BITS-1 -: ID_BITS]),
        .i_primary   (row[ID_BITS-1:0]),
        .o_owner     (new_owner),
        .o_last      (new_last),
        .o_primary   (new_primary),
        .o_stat      (stat)
    );

    // Search bookkeeping for the pipelined scan.
    assign issue     = (r_scan < SCAN_W'(SLOT_COUNT));
    assign hit       = r_chk_v && stat.free && stat.last_empty;
    assign cand      = r_chk_v && stat.free;
    assign at_last   = r_chk_v && (r_chk_idx == SLOT_W'(SLOT_COUNT - 1));
    assign none_left = !r_chk_v && !issue;

    assign ram_we = (r_state == ST_APPLY) && stat.wr;

    // Sequencer: next state, table update and result formation.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_scan       = r_scan;
        n_chk_idx    = r_chk_idx;
        n_chk_v      = r_chk_v;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_count      = r_count;
        n_done       = 1'b0;
        n_result     = r_result;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd                = i_cmd;
                    n_result             = '0;
                    n_result.usage_count = r_count;
                    case (i_cmd.kind)
                        KIND_BOOK: begin
                            if (in_id == '0) begin
                                n_done = 1'b1;
                            end else if (i_cmd.home_domain != '0) begin
                                if (int'(i_cmd.home_domain) < SLOT_COUNT) begin
                                    n_addr  = SLOT_W'(i_cmd.home_domain);
                                    n_state = ST_LOOK;
                                end else begin
                                    n_done = 1'b1;
                                end
                            end else begin
                                n_scan       = SCAN_W'(FIRST_SEARCH_SLOT);
                                n_chk_v      = 1'b0;
                                n_free_found = 1'b0;
                                n_state      = ST_SCAN;
                            end
                        end
                        KIND_CANCEL: begin
                            if (int'(i_cmd.home_domain) < SLOT_COUNT) begin
                                n_addr  = SLOT_W'(i_cmd.home_domain);
                                n_state = ST_LOOK;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        KIND_CAS, KIND_SETP, KIND_READ: begin
                            if (int'(i_cmd.target_domain) < SLOT_COUNT) begin
                                n_addr  = SLOT_W'(i_cmd.target_domain);
                                n_state = ST_LOOK;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one slot read per cycle and check the slot read in the cycle before.
                if (issue) begin
                    n_scan = r_scan + 1'b1;
                end
                n_chk_v   = issue;
                n_chk_idx = r_scan[SLOT_W-1:0];
                if (cand && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_chk_idx;
                end
                if (hit) begin
                    n_addr  = r_chk_idx;
                    n_state = ST_LOOK;
                end else if (at_last || none_left) begin
                    if (r_free_found) begin
                        n_addr  = r_free_idx;
                        n_state = ST_LOOK;
                    end else if (cand) begin
                        n_addr  = r_chk_idx;
                        n_state = ST_LOOK;
                    end else begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LOOK: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (stat.wr) begin
                    n_valid[r_addr] = 1'b1;
                end
                if (stat.claim && r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_result.usage_count = n_count;
                n_result.success     = stat.ok;
                if (r_cmd.kind == KIND_BOOK && !stat.ok) begin
                    n_result.granted_domain = '0;
                    n_result.owner_id       = '0;
                    n_result.previous_id    = '0;
                    n_result.primary_id     = '0;
                end else begin
                    n_result.granted_domain = (r_cmd.kind == KIND_BOOK) ?
                                              SLOT_IDX_W'(r_addr) : '0;
                    n_result.owner_id       = PORT_ID_W'(new_owner);
                    n_result.previous_id    = PORT_ID_W'(new_last);
                    n_result.primary_id     = PORT_ID_W'(new_primary);
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_chk_v      <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_chk_v      <= n_chk_v;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_done       <= n_done;
            r_rd_valid   <= rd_in_range && r_valid[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_scan     <= n_scan;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_result   <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Every table update is followed by a result transfer.
    a_apply_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_APPLY |=> o_done)
        else $error("update cycle not followed by a result");

    // A granted slot always comes with success.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.granted_domain != '0) |-> o_result.success)
        else $error("slot granted without success");

    // The usage count never falls outside reset.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("usage count decreased");

endmodule

// ----- verif/slot_checker.sv -----
`timescale 1ns / 1ps

module slot_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  asa_pkg::t_cmd    i_cmd,
    input  logic             i_done,
    input  asa_pkg::t_result i_result,
    output int               o_fail_count,
    output int               o_pending
);

    import asa_pkg::*;

    localparam int SLOTS        = 16;
    localparam int FIRST_SEARCH = 2;

    // Shadow copy of the slot table and the booking counter.
    logic [PORT_ID_W-1:0] owner_of   [SLOTS];
    logic [PORT_ID_W-1:0] last_of    [SLOTS];
    logic [PORT_ID_W-1:0] primary_of [SLOTS];
    logic [COUNT_W-1:0]   bookings;

    t_result slot_results_due [$];
    int      mismatches;

    assign o_fail_count = mismatches;

    // Applies one command to the shadow table and returns the result it must produce.
    function automatic t_result apply_slot_command(input t_cmd c);
        t_result               r;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  addressed;
        r         = '0;
        slot      = '0;
        addressed = 1'b0;
        case (c.kind)
            KIND_BOOK: begin
                if (c.function_id == '0) begin
                    slot = '0;
                end else if (c.home_domain != '0) begin
                    if (owner_of[c.home_domain] == '0)
                        slot = c.home_domain;
                end else begin
                    // Prefer a free slot that nobody held before; else any free slot.
                    for (int s = SLOTS - 1; s >= FIRST_SEARCH; s--) begin
                        if (owner_of[s] == '0 && last_of[s] == '0)
                            slot = SLOT_IDX_W'(s);
                    end
                    if (slot == '0) begin
                        for (int s = SLOTS - 1; s >= FIRST_SEARCH; s--) begin
                            if (owner_of[s] == '0)
                                slot = SLOT_IDX_W'(s);
                        end
                    end
                end
                if (slot != '0) begin
                    owner_of[slot] = c.function_id;
                    last_of[slot]  = c.function_id;
                    if (bookings != COUNT_MAX)
                        bookings = bookings + 1'b1;
                    r.granted_domain = slot;
                    r.success        = 1'b1;
                    addressed        = 1'b1;
                end
            end
            KIND_CAS: begin
                slot      = c.target_domain;
                addressed = 1'b1;
                if (slot != '0 && owner_of[slot] == c.expected_id) begin
                    owner_of[slot] = c.function_id;
                    r.success      = 1'b1;
                end
            end
            KIND_CANCEL: begin
                slot      = c.home_domain;
                addressed = 1'b1;
                if (last_of[slot] == c.function_id) begin
                    last_of[slot]    = '0;
                    primary_of[slot] = '0;
                end
            end
            KIND_SETP: begin
                slot             = c.target_domain;
                addressed        = 1'b1;
                primary_of[slot] = c.function_id;
            end
            KIND_READ: begin
                slot      = c.target_domain;
                addressed = 1'b1;
            end
            default: begin
            end
        endcase
        if (addressed) begin
            r.owner_id    = owner_of[slot];
            r.previous_id = last_of[slot];
            r.primary_id  = primary_of[slot];
        end
        r.usage_count = bookings;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Results are compared before a command accepted on the same edge is predicted.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                owner_of[s]   = '0;
                last_of[s]    = '0;
                primary_of[s] = '0;
            end
            bookings   = '0;
            mismatches = 0;
            slot_results_due.delete();
        end else begin
            if (i_done) begin
                if (slot_results_due.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end else begin
                    want = slot_results_due.pop_front();
                    check_field("granted_domain", COUNT_W'(want.granted_domain),
                                COUNT_W'(i_result.granted_domain));
                    check_field("success", COUNT_W'(want.success),
                                COUNT_W'(i_result.success));
                    check_field("owner_id", COUNT_W'(want.owner_id),
                                COUNT_W'(i_result.owner_id));
                    check_field("previous_id", COUNT_W'(want.previous_id),
                                COUNT_W'(i_result.previous_id));
                    check_field("primary_id", COUNT_W'(want.primary_id),
                                COUNT_W'(i_result.primary_id));
                    check_field("usage_count", want.usage_count, i_result.usage_count);
                end
            end
            if (i_start && !i_busy)
                slot_results_due.push_back(apply_slot_command(i_cmd));
        end
        o_pending <= slot_results_due.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import asa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 550;
    localparam int          DRAIN_CYCLES = 24;

    // First command code that the block does not define.
    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    logic        gaps_on = 1'b1;

    affinity_slot_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    slot_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_cmd mk_cmd(input logic [KIND_W-1:0] kind,
                                    input logic [PORT_ID_W-1:0] id,
                                    input logic [SLOT_IDX_W-1:0] home,
                                    input logic [SLOT_IDX_W-1:0] target,
                                    input logic [PORT_ID_W-1:0] expected);
        t_cmd c;
        c.kind          = kind;
        c.function_id   = id;
        c.home_domain   = home;
        c.target_domain = target;
        c.expected_id   = expected;
        return c;
    endfunction

    // A small pool of owners makes matches likely; the rest are zero or wide values.
    function automatic logic [PORT_ID_W-1:0] pick_id();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return '0;
        else if (sel < 72)
            return PORT_ID_W'($urandom_range(1, 6));
        else
            return PORT_ID_W'($urandom);
    endfunction

    // Mostly well-formed commands on few owners, with some noise and undefined codes.
    function automatic t_cmd rand_cmd();
        t_cmd        c;
        logic [63:0] noise;
        int unsigned sel;
        noise         = {$urandom, $urandom};
        c             = noise[$bits(t_cmd)-1:0];
        c.function_id = pick_id();
        c.expected_id = pick_id();
        sel           = $urandom_range(99);
        if (sel < 38) begin
            c.kind        = KIND_BOOK;
            c.home_domain = ($urandom_range(2) == 0) ? SLOT_IDX_W'($urandom_range(1, 15)) : '0;
        end else if (sel < 58) begin
            c.kind = KIND_CAS;
        end else if (sel < 70) begin
            c.kind = KIND_CANCEL;
        end else if (sel < 80) begin
            c.kind = KIND_SETP;
        end else if (sel < 95) begin
            c.kind = KIND_READ;
        end else begin
            c.kind = KIND_FIRST_UNUSED + KIND_W'($urandom_range(2));
        end
        return c;
    endfunction

    // Holds start with the command until a transfer happens; start stays high on return.
    task automatic send_cmd(input t_cmd c);
        logic [63:0] noise;
        while (gaps_on && $urandom_range(99) < 14) begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            i_cmd <= noise[$bits(t_cmd)-1:0];
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands: empty table, refusals, a search that passes over a previously held free slot, slot zero.
        send_cmd(mk_cmd(KIND_READ,   16'h0000, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_BOOK,   16'h0000, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_BOOK,   16'hFFFF, 4'd0,  4'd15, 16'hFFFF));
        send_cmd(mk_cmd(KIND_BOOK,   16'h0001, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_BOOK,   16'h1234, 4'd1,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_BOOK,   16'h5555, 4'd1,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_CAS,    16'h0007, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_CAS,    16'h0000, 4'd0,  4'd2,  16'hFFFF));
        send_cmd(mk_cmd(KIND_CAS,    16'h0009, 4'd0,  4'd3,  16'hBEEF));
        send_cmd(mk_cmd(KIND_BOOK,   16'hAAAA, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_SETP,   16'hFFFF, 4'd0,  4'd4,  16'h0000));
        send_cmd(mk_cmd(KIND_CANCEL, 16'hAAAA, 4'd4,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_CANCEL, 16'h0002, 4'd3,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_SETP,   16'h8001, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_CANCEL, 16'h0000, 4'd0,  4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_READ,   16'h0000, 4'd0,  4'd15, 16'h0000));
        send_cmd(mk_cmd(KIND_FIRST_UNUSED, 16'hFFFF, 4'd15, 4'd15, 16'hFFFF));
        send_cmd(mk_cmd({KIND_W{1'b1}},    16'hFFFF, 4'd15, 4'd15, 16'hFFFF));
        send_cmd(mk_cmd(KIND_BOOK,   16'h7FFF, 4'd15, 4'd0,  16'h0000));
        send_cmd(mk_cmd(KIND_CAS,    16'h4321, 4'd0,  4'd15, 16'h7FFF));
        send_cmd(mk_cmd(KIND_READ,   16'h0000, 4'd0,  4'd2,  16'h0000));

        // Random commands, with a long stretch of back-to-back transfers in the middle.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 220 && n < 340);
            send_cmd(rand_cmd());
        end
        start <= 1'b0;

        // Drain outstanding results, then allow time for any stray strobe.
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- affinity_slot_allocator.f -----
rtl/core/asa_pkg.sv
rtl/core/asa_ram.sv
rtl/core/asa_slot_eval.sv
rtl/core/affinity_slot_allocator.sv
verif/slot_checker.sv
verif/tb_top.sv
